// File: rtl/core/jetp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Julia escape-time pixel core.
// Used by every module under rtl/core; depends on nothing else.
package jetp_pkg;

	// Fixed-point format of coordinates and products
	localparam int FRAC_BITS = 28;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int STEP_W    = 31;
	localparam int LIMIT_W   = 16;
	localparam int COUNT_W   = LIMIT_W + 1;
	localparam int PIX_W     = 10;
	localparam int COLOR_W   = 8;

	// Escape radius squared (4.0) in the product format
	localparam int  FOUR_SHIFT = 2 * FRAC_BITS + 2;
	localparam bit  CAN_ESCAPE = (FOUR_SHIFT < PROD_W);
	localparam logic [PROD_W-1:0] FOUR_MAG = CAN_ESCAPE ?
		(PROD_W'(1) << (FOUR_SHIFT % PROD_W)) : '0;

	// Saturation bounds of a coordinate, in the product width
	localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) <<< (COORD_W - 1)) - 1;
	localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) <<< (COORD_W - 1));

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_START    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd5;

	// Register reset values
	localparam logic signed [COORD_W-1:0] RST_C_REAL     = -32'sd214748365;
	localparam logic signed [COORD_W-1:0] RST_C_IMAG     = 32'sd41875931;
	localparam logic signed [COORD_W-1:0] RST_X_START    = -32'sd268435456;
	localparam logic signed [COORD_W-1:0] RST_Y_START    = 32'sd268435456;
	localparam logic [STEP_W-1:0]         RST_PIXEL_STEP = 31'd524288;
	localparam logic [LIMIT_W-1:0]        RST_ITER_LIMIT = 16'd1000;

	typedef struct packed {
		logic signed [COORD_W-1:0] c_real;
		logic signed [COORD_W-1:0] c_imag;
		logic signed [COORD_W-1:0] x_start;
		logic signed [COORD_W-1:0] y_start;
		logic [STEP_W-1:0]         pixel_step;
		logic [LIMIT_W-1:0]        iter_limit;
	} cfg_t;

	// Operands of the three shared multipliers
	typedef struct packed {
		logic signed [COORD_W-1:0] a0;
		logic signed [COORD_W-1:0] b0;
		logic signed [COORD_W-1:0] a1;
		logic signed [COORD_W-1:0] b1;
		logic signed [COORD_W-1:0] a2;
		logic signed [COORD_W-1:0] b2;
	} sq_op_t;

	// Results derived from the registered products
	typedef struct packed {
		logic                      escape;
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
	} sq_res_t;

	// Clamp a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[COORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/jetp_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank of the Julia escape-time pixel core.
// Depends on jetp_pkg.
module jetp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jetp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output jetp_pkg::cfg_t                    cfg
);
	import jetp_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real     <= RST_C_REAL;
			cfg_q.c_imag     <= RST_C_IMAG;
			cfg_q.x_start    <= RST_X_START;
			cfg_q.y_start    <= RST_Y_START;
			cfg_q.pixel_step <= RST_PIXEL_STEP;
			cfg_q.iter_limit <= RST_ITER_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C_REAL:     cfg_q.c_real     <= cfg_data[COORD_W-1:0];
				REG_C_IMAG:     cfg_q.c_imag     <= cfg_data[COORD_W-1:0];
				REG_X_START:    cfg_q.x_start    <= cfg_data[COORD_W-1:0];
				REG_Y_START:    cfg_q.y_start    <= cfg_data[COORD_W-1:0];
				REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data[STEP_W-1:0];
				REG_ITER_LIMIT: cfg_q.iter_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/jetp_sq_unit.sv
`timescale 1ns / 1ps
// Shared complex-square unit: three 32x32 multipliers with registered
// products, then the add, shift, saturate and escape compare. Depends on jetp_pkg.
module jetp_sq_unit (
	input  logic              clk,
	input  jetp_pkg::sq_op_t  op,
	input  jetp_pkg::cfg_t    cfg,
	output jetp_pkg::sq_res_t res
);
	import jetp_pkg::*;

	logic signed [PROD_W-1:0] prod0_q;
	logic signed [PROD_W-1:0] prod1_q;
	logic signed [PROD_W-1:0] prod2_q;

	logic signed [PROD_W-1:0] cr_ext;
	logic signed [PROD_W-1:0] ci_ext;
	logic signed [PROD_W-1:0] xs_ext;
	logic signed [PROD_W-1:0] ys_ext;
	logic signed [PROD_W-1:0] diff;
	logic signed [PROD_W-1:0] nx_wide;
	logic signed [PROD_W-1:0] ny_wide;
	logic signed [PROD_W-1:0] x0_wide;
	logic signed [PROD_W-1:0] y0_wide;
	logic [PROD_W-1:0]        mag;

	// Multiply and hold the products
	always_ff @(posedge clk) begin
		prod0_q <= PROD_W'(op.a0) * PROD_W'(op.b0);
		prod1_q <= PROD_W'(op.a1) * PROD_W'(op.b1);
		prod2_q <= PROD_W'(op.a2) * PROD_W'(op.b2);
	end

	// Sign-extend the constants
	assign cr_ext = PROD_W'(cfg.c_real);
	assign ci_ext = PROD_W'(cfg.c_imag);
	assign xs_ext = PROD_W'(cfg.x_start);
	assign ys_ext = PROD_W'(cfg.y_start);

	// Next iterate: floor shifts, add c, clamp
	assign diff    = prod0_q - prod1_q;
	assign nx_wide = (diff >>> FRAC_BITS) + cr_ext;
	assign ny_wide = (prod2_q >>> (FRAC_BITS - 1)) + ci_ext;

	// Seed point: products are col*step and row*step here
	assign x0_wide = xs_ext + prod0_q;
	assign y0_wide = ys_ext - prod1_q;

	// Squares are non-negative, so the unsigned sum is exact
	assign mag = prod0_q + prod1_q;

	assign res.escape = CAN_ESCAPE && (mag > FOUR_MAG);
	assign res.nx     = sat_coord(nx_wide);
	assign res.ny     = sat_coord(ny_wide);
	assign res.x0     = sat_coord(x0_wide);
	assign res.y0     = sat_coord(y0_wide);

endmodule

// File: rtl/core/julia_escape_time_pixel.sv
`timescale 1ns / 1ps
// Top level of the Julia escape-time pixel core: command port, sequencer,
// iterate registers and color output. Depends on jetp_pkg, jetp_cfg, jetp_sq_unit.
//
//  Port group    Direction  Transfer rule
//  start/pixel_* in         taken at a clock edge with start high and busy low
//  cfg_*         in         register written at a clock edge with cfg_we high
//  done/results  out        valid for one cycle while done is high
//
// An accepted pixel goes through ST_LOAD to form col*step and row*step,
// ST_SEED to seed z, then ST_MUL (multiply) and ST_TEST (add/compare) for
// each of the iter_count + 1 tests, on the single shared complex-square unit.
// busy is high from the cycle after a transfer until done; a new pixel may
// start in the done cycle. arst_n clears the sequencer and loads the register
// reset values. The receiver cannot stall; each result shows exactly once.
module julia_escape_time_pixel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [jetp_pkg::PIX_W-1:0]        pixel_row,
	input  logic [jetp_pkg::PIX_W-1:0]        pixel_col,
	input  logic                              cfg_we,
	input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jetp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output logic [jetp_pkg::COUNT_W-1:0]      iter_count,
	output logic [jetp_pkg::COLOR_W-1:0]      red,
	output logic [jetp_pkg::COLOR_W-1:0]      green,
	output logic [jetp_pkg::COLOR_W-1:0]      blue
);
	import jetp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SEED = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_TEST = 3'd4;

	cfg_t    cfg;
	sq_op_t  sq_op;
	sq_res_t sq_res;

	logic [2:0]                state_q;
	logic [PIX_W-1:0]          row_q;
	logic [PIX_W-1:0]          col_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      done_q;
	logic [COUNT_W-1:0]        iter_count_q;
	logic [COLOR_W-1:0]        red_q;
	logic [COLOR_W-1:0]        green_q;
	logic [COLOR_W-1:0]        blue_q;
	logic                      accept;
	logic                      past_limit;

	jetp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jetp_sq_unit u_sq (
		.clk (clk),
		.op  (sq_op),
		.cfg (cfg),
		.res (sq_res)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign past_limit = (count_q > {1'b0, cfg.iter_limit});

	// Steer the shared multipliers: seed products while loading, else x*x, y*y, x*y
	always_comb begin
		sq_op.a2 = x_q;
		sq_op.b2 = y_q;
		if (state_q == ST_LOAD) begin
			sq_op.a0 = $signed({{(COORD_W-PIX_W){1'b0}}, col_q});
			sq_op.b0 = $signed({{(COORD_W-STEP_W){1'b0}}, cfg.pixel_step});
			sq_op.a1 = $signed({{(COORD_W-PIX_W){1'b0}}, row_q});
			sq_op.b1 = $signed({{(COORD_W-STEP_W){1'b0}}, cfg.pixel_step});
		end else begin
			sq_op.a0 = x_q;
			sq_op.b0 = x_q;
			sq_op.a1 = y_q;
			sq_op.b1 = y_q;
		end
	end

	// Sequencer: load, seed, then alternate multiply and test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_SEED;
				ST_SEED: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_TEST;
				ST_TEST: begin
					if (past_limit || sq_res.escape) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the pixel, the iterate and the count
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= pixel_row;
			col_q <= pixel_col;
		end
		if (state_q == ST_SEED) begin
			x_q     <= sq_res.x0;
			y_q     <= sq_res.y0;
			count_q <= '0;
		end else if (state_q == ST_TEST && !past_limit && !sq_res.escape) begin
			x_q     <= sq_res.nx;
			y_q     <= sq_res.ny;
			count_q <= count_q + COUNT_W'(1);
		end
	end

	// Register the result; black when the point never escaped
	always_ff @(posedge clk) begin
		if (state_q == ST_TEST && (past_limit || sq_res.escape)) begin
			iter_count_q <= count_q;
			if (past_limit) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else begin
				red_q   <= {count_q[COLOR_W-3:0], 2'b00};
				green_q <= {count_q[COLOR_W-2:0], 1'b0};
				blue_q  <= {count_q[COLOR_W-3:0], 2'b00} + {count_q[COLOR_W-2:0], 1'b0};
			end
		end
	end

	assign done       = done_q;
	assign iter_count = iter_count_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;

	// A result only appears once the sequencer is back to idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while sequencer busy");

	// An accepted pixel always occupies the sequencer next cycle
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted pixel did not start the sequencer");

	// The count never runs past the limit plus one
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (iter_count <= ({1'b0, cfg.iter_limit} + COUNT_W'(1))))
		else $error("iteration count beyond limit plus one");

	// A point that never escaped is black
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (iter_count > {1'b0, cfg.iter_limit})) |->
		(red == '0 && green == '0 && blue == '0))
		else $error("inside point not black");

endmodule
